// File: sv/cdds_pkg.sv
// cdds_pkg: constants, month tables and pipeline stage types for the
// civil date to day/second converter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cdds_pkg;

   // calendar constants
   localparam int unsigned SECS_PER_DAY   = 86400;
   localparam int unsigned DAYS_PER_CYCLE = (400 * 365) + 97;

   // accepted zone offset range, minutes west
   localparam logic signed [10:0] ZONE_MIN = -11'sd720;
   localparam logic signed [10:0] ZONE_MAX = 11'sd720;

   // year / 400 as (year >> 4) / 25, with 1/25 taken as 1311 / 2^15
   localparam logic [10:0] DIV25_MUL   = 11'd1311;
   localparam int unsigned DIV25_SHIFT = 15;

   // month codes used by the leap adjustments
   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   // days in a month of a common year, zero for a code that is no month
   function automatic logic [4:0] month_len(input logic [3:0] month);
      logic [4:0] len;
      case (month)
         4'd1:    len = 5'd31;
         4'd2:    len = 5'd28;
         4'd3:    len = 5'd31;
         4'd4:    len = 5'd30;
         4'd5:    len = 5'd31;
         4'd6:    len = 5'd30;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd31;
         4'd9:    len = 5'd30;
         4'd10:   len = 5'd31;
         4'd11:   len = 5'd30;
         4'd12:   len = 5'd31;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   // days before the first of the month in a common year
   function automatic logic [8:0] month_start(input logic [3:0] month);
      logic [8:0] start;
      case (month)
         4'd1:    start = 9'd0;
         4'd2:    start = 9'd31;
         4'd3:    start = 9'd59;
         4'd4:    start = 9'd90;
         4'd5:    start = 9'd120;
         4'd6:    start = 9'd151;
         4'd7:    start = 9'd181;
         4'd8:    start = 9'd212;
         4'd9:    start = 9'd243;
         4'd10:   start = 9'd273;
         4'd11:   start = 9'd304;
         4'd12:   start = 9'd334;
         default: start = 9'd0;
      endcase
      return start;
   endfunction

   // stage 1: range checks done, year split started, local seconds summed
   typedef struct packed {
      logic               ok;
      logic [13:0]        year;
      logic [3:0]         month;
      logic [4:0]         mday;
      logic [5:0]         q400;
      logic signed [18:0] secs;
   } s1_type;

   // stage 2: year within cycle, cycle days, day of year with carry
   typedef struct packed {
      logic               ok;
      logic [8:0]         y4;
      logic signed [22:0] cyc_days;
      logic signed [9:0]  mon_days;
      logic [16:0]        sec;
   } s2_type;

   // stage 3: days of the years within the cycle, partial day sum
   typedef struct packed {
      logic               ok;
      logic [17:0]        yr_days;
      logic signed [22:0] base;
      logic [16:0]        sec;
   } s3_type;

endpackage

`default_nettype wire

// File: sv/civil_date_to_day_second.sv
// civil_date_to_day_second: four stage pipeline converting a local Gregorian
// date and time with zone offset to a UTC day number and second of day.
// Depends on cdds_pkg.
//
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  zone, year, month, day, hour, min, sec
//  rsp_      out        rsp_valid/rsp_stall  valid_res, day_number, second_of_day
//
// One request enters per cycle while req_stall is low. Requests pass through
// the four register stages: checks and year/400, leap and day-of-year,
// years-in-cycle days, final sum into the output register.
// Each stage moves when it is empty or the stage after it moves, so bubbles
// close up and requests are taken while a finished response waits.
// Reset (synchronous, active high) clears the stage valid bits only.
`timescale 1ns / 1ps
`default_nettype none

module civil_date_to_day_second
   import cdds_pkg::*;
#(
   parameter int unsigned YEAR_MAX = 9999
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic signed [10:0] req_zone_minutes_west,
   input  wire logic [13:0]        req_year_in,
   input  wire logic [3:0]         req_month_in,
   input  wire logic [4:0]         req_day_of_month,
   input  wire logic [4:0]         req_hour_in,
   input  wire logic [5:0]         req_minute_in,
   input  wire logic [5:0]         req_second_in,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic               rsp_valid_res,
   output      logic signed [22:0] rsp_day_number,
   output      logic [16:0]        rsp_second_of_day
);

   localparam logic [16:0] YEAR_LIMIT = 17'(YEAR_MAX);

   logic   v1_ff, v2_ff, v3_ff, v4_ff;
   logic   en1, en2, en3, en4;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   logic               res_ok_ff, res_ok_in;
   logic signed [22:0] res_day_ff, res_day_in;
   logic [16:0]        res_sec_ff, res_sec_in;

   // stage enables: a stage moves when empty or when its successor moves
   always_comb begin
      en4 = !v4_ff || !rsp_stall;
      en3 = !v3_ff || en4;
      en2 = !v2_ff || en3;
      en1 = !v1_ff || en2;
   end

   assign req_stall = !en1;

   // stage 1: field checks, year / 400, local seconds plus zone offset
   logic [16:0]        tod;
   logic signed [18:0] zone_secs;
   logic [20:0]        qprod;
   always_comb begin
      tod       = 17'(req_hour_in) * 17'd3600 + 17'(req_minute_in) * 17'd60
                  + 17'(req_second_in);
      zone_secs = 19'(req_zone_minutes_west) * 19'sd60;
      qprod     = 21'(req_year_in[13:4]) * 21'(DIV25_MUL);
      s1_in.ok    = (req_zone_minutes_west >= ZONE_MIN)
                    && (req_zone_minutes_west <= ZONE_MAX)
                    && ({3'd0, req_year_in} <= YEAR_LIMIT)
                    && (req_month_in >= MONTH_JAN) && (req_month_in <= MONTH_DEC)
                    && (req_hour_in <= 5'd23) && (req_minute_in <= 6'd59)
                    && (req_second_in <= 6'd59) && (req_day_of_month != 5'd0);
      s1_in.year  = req_year_in;
      s1_in.month = req_month_in;
      s1_in.mday  = req_day_of_month;
      s1_in.q400  = qprod[DIV25_SHIFT +: 6];
      s1_in.secs  = $signed({2'b00, tod}) + zone_secs;
   end

   // stage 2: year within cycle, leap rule, month length, day carry
   logic [14:0] q400x;
   logic [8:0]  y4;
   logic        leap;
   logic [4:0]  mlen;
   logic [23:0] cyc_prod;
   logic signed [1:0] adj;
   always_comb begin
      q400x    = 15'(s1_ff.q400) * 15'd400;
      y4       = 9'(15'(s1_ff.year) - q400x);
      leap     = (s1_ff.year[1:0] == 2'b00) && (y4 != 9'd100) && (y4 != 9'd200)
                 && (y4 != 9'd300);
      mlen     = month_len(s1_ff.month)
                 + 5'((leap && (s1_ff.month == MONTH_FEB)) ? 1 : 0);
      cyc_prod = 24'(s1_ff.q400) * 24'(DAYS_PER_CYCLE);
      if (s1_ff.secs < 0) begin
         adj       = -2'sd1;
         s2_in.sec = 17'(s1_ff.secs + 19'(SECS_PER_DAY));
      end else if (s1_ff.secs >= $signed(19'(SECS_PER_DAY))) begin
         adj       = 2'sd1;
         s2_in.sec = 17'(s1_ff.secs - 19'(SECS_PER_DAY));
      end else begin
         adj       = 2'sd0;
         s2_in.sec = 17'(s1_ff.secs);
      end
      s2_in.ok       = s1_ff.ok && (s1_ff.mday <= mlen);
      s2_in.y4       = y4;
      s2_in.cyc_days = $signed(cyc_prod[22:0]);
      s2_in.mon_days = $signed({1'b0, month_start(s1_ff.month)})
                       + $signed(10'((leap && (s1_ff.month > MONTH_FEB)) ? 1 : 0))
                       + $signed(10'(s1_ff.mday)) - 10'sd1
                       + {{8{adj[1]}}, adj};
   end

   function automatic logic y4_gt(input logic [8:0] a, input logic [8:0] b);
      return a > b;
   endfunction

   // stage 3: days of the years before this one in the 400-year cycle
   logic [1:0] cent;
   logic [9:0] quad;
   always_comb begin
      cent = 2'((y4_gt(s2_ff.y4, 9'd100) ? 1 : 0) + (y4_gt(s2_ff.y4, 9'd200) ? 1 : 0)
                + (y4_gt(s2_ff.y4, 9'd300) ? 1 : 0));
      quad = (10'(s2_ff.y4) + 10'd3) >> 2;
      s3_in.ok      = s2_ff.ok;
      s3_in.yr_days = 18'(s2_ff.y4) * 18'd365 + 18'(quad) - 18'(cent);
      s3_in.base    = s2_ff.cyc_days + {{13{s2_ff.mon_days[9]}}, s2_ff.mon_days};
      s3_in.sec     = s2_ff.sec;
   end

   // stage 4: final day sum, zeroed fields for a rejected request
   always_comb begin
      res_ok_in  = s3_ff.ok;
      res_day_in = s3_ff.ok ? (s3_ff.base + $signed({5'd0, s3_ff.yr_days})) : 23'sd0;
      res_sec_in = s3_ff.ok ? s3_ff.sec : 17'd0;
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (en1) s1_ff <= s1_in;
      if (en2) s2_ff <= s2_in;
      if (en3) s3_ff <= s3_in;
      if (en4) begin
         res_ok_ff  <= res_ok_in;
         res_day_ff <= res_day_in;
         res_sec_ff <= res_sec_in;
      end
   end

   assign rsp_valid         = v4_ff;
   assign rsp_valid_res     = res_ok_ff;
   assign rsp_day_number    = res_day_ff;
   assign rsp_second_of_day = res_sec_ff;

   // a rejected request carries zero day and second
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_day_number == 23'sd0
                                      && rsp_second_of_day == 17'd0)
      else $error("rejected response has nonzero fields");

   // second of day stays inside one day
   a_sec_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_second_of_day < 17'(SECS_PER_DAY))
      else $error("second of day out of range");

   // an accepted date never lands more than one day before day zero
   a_day_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |-> rsp_day_number >= -23'sd1)
      else $error("day number below minus one");

   // input is held off only while every stage is full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff && v2_ff && v3_ff && v4_ff)
      else $error("request stalled with a free stage");

   // stage 2 carry leaves the second inside one day
   a_s2_sec: assert property (@(posedge clock) disable iff (reset)
      v2_ff && s2_ff.ok |-> s2_ff.sec < 17'(SECS_PER_DAY))
      else $error("carry stage second out of range");

endmodule

`default_nettype wire

// File: tb/civil_date_to_day_second_tb.sv
// civil_date_to_day_second_tb: self-checking testbench for the civil date to
// UTC day/second converter, with its own calendar predictor and idle phases.
// Depends on cdds_pkg and civil_date_to_day_second.
`timescale 1ns / 1ps

module civil_date_to_day_second_tb
   import cdds_pkg::*;
();

   localparam int YEAR_LIMIT     = 9999;
   localparam int ZONE_SPAN      = 720;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 16;

   // one request as driven on the req_ ports
   typedef struct packed {
      logic signed [10:0] zone;
      logic [13:0]        year;
      logic [3:0]         month;
      logic [4:0]         mday;
      logic [4:0]         hour;
      logic [5:0]         minute;
      logic [5:0]         second;
   } civil_req_type;

   // one response as seen on the rsp_ ports
   typedef struct packed {
      logic               ok;
      logic signed [22:0] day;
      logic [16:0]        sod;
   } utc_stamp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [10:0] req_zone_minutes_west = '0;
   logic [13:0]        req_year_in = '0;
   logic [3:0]         req_month_in = '0;
   logic [4:0]         req_day_of_month = '0;
   logic [4:0]         req_hour_in = '0;
   logic [5:0]         req_minute_in = '0;
   logic [5:0]         req_second_in = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_valid_res;
   logic signed [22:0] rsp_day_number;
   logic [16:0]        rsp_second_of_day;

   utc_stamp_type expected_utc[$];
   int idle_pct = 0;
   int stall_pct = 0;
   int error_count = 0;
   int quiet_cycles = 0;

   civil_date_to_day_second #(
      .YEAR_MAX(YEAR_LIMIT)
   ) dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_zone_minutes_west (req_zone_minutes_west),
      .req_year_in           (req_year_in),
      .req_month_in          (req_month_in),
      .req_day_of_month      (req_day_of_month),
      .req_hour_in           (req_hour_in),
      .req_minute_in         (req_minute_in),
      .req_second_in         (req_second_in),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_valid_res         (rsp_valid_res),
      .rsp_day_number        (rsp_day_number),
      .rsp_second_of_day     (rsp_second_of_day)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // calendar helpers
   function automatic bit leap_year(input int year);
      return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
   endfunction

   function automatic int month_days(input int year, input int month);
      case (month)
         MONTH_FEB:     return leap_year(year) ? 29 : 28;
         4, 6, 9, 11:   return 30;
         default:       return 31;
      endcase
   endfunction

   // expected UTC day number and second of day for one request
   function automatic utc_stamp_type predict_utc(input civil_req_type r);
      utc_stamp_type res;
      int zone, year, month, mday, days, secs, cyc_year;
      res = '0;
      zone = r.zone;
      year = r.year;
      month = r.month;
      mday = r.mday;
      if (zone < -ZONE_SPAN || zone > ZONE_SPAN) return res;
      if (year > YEAR_LIMIT || month < 1 || month > 12) return res;
      if (r.hour > 23 || r.minute > 59 || r.second > 59) return res;
      if (mday < 1 || mday > month_days(year, month)) return res;

      // days before this month, leap day included
      days = 0;
      for (int m = 1; m < month; m++) days += month_days(year, m);
      // whole 400 year cycles, then years inside the cycle
      days += (year / 400) * DAYS_PER_CYCLE;
      cyc_year = year % 400;
      days += cyc_year * 365 + (cyc_year + 3) / 4;
      if (cyc_year > 0) days -= (cyc_year - 1) / 100;
      days += mday - 1;

      // shift to UTC with borrow or carry of one day
      secs = int'(r.hour) * 3600 + int'(r.minute) * 60 + int'(r.second) + zone * 60;
      if (secs < 0) begin
         days -= 1;
         secs += SECS_PER_DAY;
      end else if (secs >= SECS_PER_DAY) begin
         days += 1;
         secs -= SECS_PER_DAY;
      end
      res.ok = 1'b1;
      res.day = days[22:0];
      res.sod = secs[16:0];
      return res;
   endfunction

   function automatic civil_req_type date_of(input int zone, input int year, input int month,
                                             input int mday, input int hour, input int minute,
                                             input int second);
      civil_req_type r;
      r.zone = 11'(zone);
      r.year = 14'(year);
      r.month = 4'(month);
      r.mday = 5'(mday);
      r.hour = 5'(hour);
      r.minute = 6'(minute);
      r.second = 6'(second);
      return r;
   endfunction

   // mostly well-formed dates, some with one bad field, some raw noise
   function automatic civil_req_type random_date();
      civil_req_type r;
      int pick, zone, year, month, mlen;
      pick = $urandom_range(0, 99);
      if (pick >= 85) begin
         r.zone = 11'($urandom);
         r.year = 14'($urandom);
         r.month = 4'($urandom);
         r.mday = 5'($urandom);
         r.hour = 5'($urandom);
         r.minute = 6'($urandom);
         r.second = 6'($urandom);
         return r;
      end
      zone = $urandom_range(0, 2 * ZONE_SPAN);
      zone -= ZONE_SPAN;
      case ($urandom_range(0, 9))
         0:       zone = ZONE_SPAN;
         1:       zone = -ZONE_SPAN;
         2:       zone = 0;
         default: ;
      endcase
      year = $urandom_range(0, YEAR_LIMIT);
      if ($urandom_range(0, 7) == 0) year = (year / 100) * 100;
      month = $urandom_range(1, 12);
      mlen = month_days(year, month);
      r = date_of(zone, year, month, $urandom_range(1, mlen), $urandom_range(0, 23),
                  $urandom_range(0, 59), $urandom_range(0, 59));
      // day edges so the zone shift borrows or carries
      case ($urandom_range(0, 9))
         0: begin
            r.mday = 5'(mlen);
            r.hour = 5'd23;
            r.minute = 6'd59;
            r.second = 6'd59;
         end
         1: begin
            r.mday = 5'd1;
            r.hour = 5'd0;
            r.minute = 6'd0;
            r.second = 6'd0;
         end
         default: ;
      endcase
      if (pick < 70) return r;

      // break exactly one field
      case ($urandom_range(0, 6))
         0: begin
            zone = $urandom_range(ZONE_SPAN + 1, 1024);
            r.zone = 11'($urandom_range(0, 1) ? zone : -zone);
         end
         1: r.year = 14'($urandom_range(YEAR_LIMIT + 1, 16383));
         2: r.month = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
         3: r.mday = (mlen == 31 || $urandom_range(0, 1)) ? 5'd0
                     : 5'($urandom_range(mlen + 1, 31));
         4: r.hour = 5'($urandom_range(24, 31));
         5: r.minute = 6'($urandom_range(60, 63));
         default: r.second = 6'($urandom_range(60, 63));
      endcase
      return r;
   endfunction

   // send one request, with random idle cycles ahead of it
   task automatic send_date(input civil_req_type r);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_zone_minutes_west <= r.zone;
      req_year_in <= r.year;
      req_month_in <= r.month;
      req_day_of_month <= r.mday;
      req_hour_in <= r.hour;
      req_minute_in <= r.minute;
      req_second_in <= r.second;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_utc.push_back(predict_utc(r));
   endtask

   // stop sending and wait for every outstanding response
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_utc.size() != 0) @(posedge clock);
   endtask

   task automatic run_random(input int count);
      repeat (count) send_date(random_date());
   endtask

   // calendar extremes and every special case, back to back
   task automatic test_calendar_edges();
      idle_pct = 0;
      stall_pct = 0;
      send_date(date_of(0, 0, MONTH_JAN, 1, 0, 0, 0));
      send_date(date_of(-ZONE_SPAN, 0, MONTH_JAN, 1, 0, 0, 0));
      send_date(date_of(ZONE_SPAN, YEAR_LIMIT, MONTH_DEC, 31, 23, 59, 59));
      send_date(date_of(-ZONE_SPAN, YEAR_LIMIT, MONTH_DEC, 31, 23, 59, 59));
      send_date(date_of(60, 2023, 6, 15, 23, 0, 0));
      send_date(date_of(ZONE_SPAN, 2023, 3, 1, 12, 0, 0));
      // leap day in leap and common years
      send_date(date_of(0, 0, MONTH_FEB, 29, 12, 0, 0));
      send_date(date_of(0, 2000, MONTH_FEB, 29, 12, 0, 0));
      send_date(date_of(0, 1900, MONTH_FEB, 29, 12, 0, 0));
      send_date(date_of(0, 2001, MONTH_FEB, 29, 12, 0, 0));
      send_date(date_of(0, 2004, MONTH_FEB, 29, 12, 0, 0));
      // fields just out of range and at their raw extremes
      send_date(date_of(ZONE_SPAN + 1, 2020, 5, 5, 5, 5, 5));
      send_date(date_of(-ZONE_SPAN - 1, 2020, 5, 5, 5, 5, 5));
      send_date(date_of(1023, 2020, 5, 5, 5, 5, 5));
      send_date(date_of(-1024, 2020, 5, 5, 5, 5, 5));
      send_date(date_of(0, YEAR_LIMIT + 1, MONTH_JAN, 1, 0, 0, 0));
      send_date(date_of(0, 16383, MONTH_JAN, 1, 0, 0, 0));
      send_date(date_of(0, 2020, 0, 1, 0, 0, 0));
      send_date(date_of(0, 2020, 13, 1, 0, 0, 0));
      send_date(date_of(0, 2020, 15, 1, 0, 0, 0));
      send_date(date_of(0, 2020, 4, 0, 0, 0, 0));
      send_date(date_of(0, 2020, 4, 31, 0, 0, 0));
      send_date(date_of(0, 2020, 7, 7, 24, 0, 0));
      send_date(date_of(0, 2020, 7, 7, 31, 63, 63));
      send_date(date_of(0, 2020, 7, 7, 0, 60, 60));
   endtask

   task automatic test_streaming();
      idle_pct = 0;
      stall_pct = 0;
      run_random(450);
   endtask

   task automatic test_sender_gaps();
      idle_pct = 55;
      stall_pct = 0;
      run_random(450);
   endtask

   task automatic test_receiver_stalls();
      idle_pct = 0;
      stall_pct = 55;
      run_random(450);
   endtask

   task automatic test_mixed_idling();
      idle_pct = 37;
      stall_pct = 37;
      run_random(450);
   endtask

   // bursts separated by a full drain of the pipeline
   task automatic test_drain_pauses();
      idle_pct = 0;
      stall_pct = 37;
      repeat (5) begin
         run_random(30);
         drain_results();
      end
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // response checker
   always @(posedge clock) begin
      utc_stamp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_utc.size() == 0) begin
            $error("response with no request outstanding: valid_res %0d day_number %0d",
                   rsp_valid_res, rsp_day_number);
            error_count++;
         end else begin
            want = expected_utc.pop_front();
            if (rsp_valid_res !== want.ok) begin
               $error("valid_res: expected %0d, got %0d", want.ok, rsp_valid_res);
               error_count++;
            end
            if (rsp_day_number !== want.day) begin
               $error("day_number: expected %0d, got %0d", want.day, rsp_day_number);
               error_count++;
            end
            if (rsp_second_of_day !== want.sod) begin
               $error("second_of_day: expected %0d, got %0d", want.sod, rsp_second_of_day);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("civil_date_to_day_second_tb: done, errors");
         $finish;
      end
   end

   // test sequence
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_calendar_edges();
      test_streaming();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_idling();
      test_drain_pauses();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("civil_date_to_day_second_tb: done, clean");
      end else begin
         $display("civil_date_to_day_second_tb: done, errors");
      end
      $finish;
   end

endmodule
